// ===== sv/pfla_pkg.sv =====
package pfla_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int INIT_PAGES = 16;

    // pool size right after reset
    localparam int INIT_EFF = (INIT_PAGES > MAX_PAGES) ? MAX_PAGES : INIT_PAGES;

    localparam int PW     = $clog2(MAX_PAGES);   // page index width
    localparam int CW     = PW + 1;              // page count width
    localparam int PN_W   = 10;                  // page_number / given_page width
    localparam int CMP_W  = (PN_W > CW) ? PN_W : CW;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOC       = 2'd0;
    localparam logic [1:0] ST_ALLOC_GROWN = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;
    localparam logic [1:0] ST_FREED       = 2'd3;

    typedef struct packed {
        logic          vld;
        logic [PW-1:0] pg;
    } t_link;

    // controller -> datapath
    typedef struct packed {
        logic walk;        // write one link of the walker, advance it
        logic grow_start;  // head <= count, count <= 2*count, walker <= old count
        logic push;        // free: push page onto head
        logic rd;          // read link of head page
        logic pop;         // take head, report it
        logic pop_grown;   // pop follows a pool doubling
        logic full;        // report out of capacity
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic head_valid;
        logic full;        // doubling would pass MAX_PAGES
        logic walk_last;
    } t_sts;

endpackage

// ===== sv/pfla_dp.sv =====
module pfla_dp
    import pfla_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  logic [PN_W-1:0] i_page_number,
    output t_sts            o_sts,
    output logic            o_valid,
    output logic [PN_W-1:0] o_given_page,
    output logic [1:0]      o_status
);

    t_link           r_link_mem [MAX_PAGES];
    t_link           r_rd;
    logic [PW-1:0]   r_head;
    logic            r_head_valid;
    logic [CW-1:0]   r_pc;
    logic [PW-1:0]   r_walk;
    logic            r_valid;
    logic [PN_W-1:0] r_given;
    logic [1:0]      r_status;

    logic [CW-1:0]   walk_nxt;
    logic [CW:0]     doubled;
    logic            pgn_ok;
    logic [PW-1:0]   pgn_idx;
    logic            mem_we;
    logic [PW-1:0]   mem_waddr;
    t_link           mem_wdata;

    assign walk_nxt = CW'(r_walk) + CW'(1);
    assign doubled  = {r_pc, 1'b0};
    assign pgn_ok   = CMP_W'(i_page_number) < CMP_W'(MAX_PAGES);
    assign pgn_idx  = PW'(i_page_number);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_walk;
        mem_wdata = '0;
        if (i_cmd.walk) begin
            mem_we        = 1'b1;
            mem_wdata.vld = (walk_nxt != r_pc);
            mem_wdata.pg  = (walk_nxt != r_pc) ? walk_nxt[PW-1:0] : '0;
        end else if (i_cmd.push && pgn_ok) begin
            mem_we        = 1'b1;
            mem_waddr     = pgn_idx;
            mem_wdata.vld = r_head_valid;
            mem_wdata.pg  = r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rd <= r_link_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= PW'(1);
            r_head_valid <= 1'b1;
            r_pc         <= CW'(INIT_EFF);
            r_walk       <= PW'(1);
            r_valid      <= 1'b0;
        end else begin
            r_valid <= i_cmd.push | i_cmd.pop | i_cmd.full;
            if (i_cmd.walk) begin
                r_walk <= walk_nxt[PW-1:0];
            end
            if (i_cmd.grow_start) begin
                r_walk       <= r_pc[PW-1:0];
                r_head       <= r_pc[PW-1:0];
                r_head_valid <= 1'b1;
                r_pc         <= doubled[CW-1:0];
            end
            if (i_cmd.push && pgn_ok) begin
                r_head       <= pgn_idx;
                r_head_valid <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_head       <= r_rd.pg;
                r_head_valid <= r_rd.vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_given  <= PN_W'(r_head);
            r_status <= i_cmd.pop_grown ? ST_ALLOC_GROWN : ST_ALLOC;
        end else if (i_cmd.full) begin
            r_given  <= '0;
            r_status <= ST_FULL;
        end else if (i_cmd.push) begin
            r_given  <= '0;
            r_status <= ST_FREED;
        end
    end

    assign o_sts.head_valid = r_head_valid;
    assign o_sts.full       = doubled > (CW+1)'(MAX_PAGES);
    assign o_sts.walk_last  = (walk_nxt == r_pc);
    assign o_valid          = r_valid;
    assign o_given_page     = r_given;
    assign o_status         = r_status;

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= CW'(MAX_PAGES))
        else $error("page count beyond pool limit");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.walk && i_cmd.push))
        else $error("walker and push collide on link memory");

    a_rd_valid_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> r_head_valid)
        else $error("link read of an empty list head");

    a_result_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop || i_cmd.full || i_cmd.push) |=> o_valid)
        else $error("missing result strobe");

endmodule

// ===== sv/pfla_ctrl.sv =====
module pfla_ctrl
    import pfla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_opcode,
    input  t_sts i_sts,
    output logic o_busy,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_GROW = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_POP  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_grown;
    logic       n_grown;
    logic       accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_grown = r_grown;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_FREE) begin
                        o_cmd.push = 1'b1;
                    end else if (i_sts.head_valid) begin
                        o_cmd.rd = 1'b1;
                        n_grown  = 1'b0;
                        n_state  = S_POP;
                    end else if (i_sts.full) begin
                        o_cmd.full = 1'b1;
                    end else begin
                        o_cmd.grow_start = 1'b1;
                        n_grown          = 1'b1;
                        n_state          = S_GROW;
                    end
                end
            end
            S_GROW: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_POP;
            end
            S_POP: begin
                o_cmd.pop       = 1'b1;
                o_cmd.pop_grown = r_grown;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_grown <= 1'b0;
        end else begin
            r_state <= n_state;
            r_grown <= n_grown;
        end
    end

    a_pop_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_state == S_IDLE))
        else $error("pop did not return to idle");

    a_grow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.grow_start |-> (!i_sts.head_valid && !i_sts.full))
        else $error("doubling started with a usable list");

    a_read_then_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_POP && r_grown))
        else $error("read after doubling not followed by pop");

endmodule

// ===== sv/page_free_list_allocator.sv =====
// Free-list page allocator. A transaction is taken when start is high and busy is low;
// its result is on o_given_page/o_status with o_valid high for exactly one cycle, in the
// first cycle after the transaction in which busy is low again, and the receiver cannot
// stall it. A free, and an allocate on an empty list when the pool is full, keep busy
// low (a new transaction may follow at once; its result shows in the very next cycle);
// any other allocate makes one registered read of the link memory, then the pop. An
// allocate on an empty list doubles the pool first (when that stays within MAX_PAGES):
// the link walker writes one link per cycle, so busy stays high while it links the new
// pages, then for the read and the pop. After reset the same walker links the initial
// chain, holding busy high before the first transaction.
module page_free_list_allocator
    import pfla_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_opcode,
    input  logic [PN_W-1:0] i_page_number,
    output logic            o_valid,
    output logic [PN_W-1:0] o_given_page,
    output logic [1:0]      o_status
);

    t_cmd cmd;
    t_sts sts;

    pfla_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    pfla_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_page_number (i_page_number),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_given_page  (o_given_page),
        .o_status      (o_status)
    );

endmodule

// ===== test/page_free_list_allocator_tb.sv =====
module page_free_list_allocator_tb;
    import pfla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM      = 1380;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic            op;
        logic [PN_W-1:0] pg;
        bit              drain;   // hold off until all replies are back
    } t_page_req;

    typedef struct {
        logic [PN_W-1:0] page;
        logic [1:0]      st;
    } t_page_reply;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic            i_opcode = OP_ALLOC;
    logic [PN_W-1:0] i_page_number = '0;
    logic            o_valid;
    logic [PN_W-1:0] o_given_page;
    logic [1:0]      o_status;

    t_page_req       pending_reqs[$];
    t_page_reply     awaited_replies[$];
    logic [PW-1:0]   lent_pages[$];     // pages handed out and not yet given back
    logic [PN_W-1:0] chunk_frees[$];

    // free list mirror
    logic [PW-1:0]   fl_head;
    bit              fl_head_ok;
    logic [CW-1:0]   pool_pages;
    logic [PW-1:0]   fl_next[MAX_PAGES];
    bit              fl_next_ok[MAX_PAGES];
    bit              full_seen = 1'b0;

    bit              acc_q = 1'b0;
    int              idle_pct = 0;
    int              mismatches = 0;
    int              cycle_cnt = 0;
    int              idle_sched[4] = '{0, 53, 0, 28};

    page_free_list_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_page_number (i_page_number),
        .o_valid       (o_valid),
        .o_given_page  (o_given_page),
        .o_status      (o_status)
    );

    always #6 i_clk = ~i_clk;

    task automatic link_pages(input int first, input int stop);
        int i;
        for (i = first; i < stop && i < MAX_PAGES; i++) begin
            if (i + 1 < stop) begin
                fl_next[i]    = PW'(i + 1);
                fl_next_ok[i] = 1'b1;
            end else begin
                fl_next[i]    = '0;
                fl_next_ok[i] = 1'b0;
            end
        end
    endtask

    task automatic clear_free_list();
        int i;
        for (i = 0; i < MAX_PAGES; i++) begin
            fl_next[i]    = '0;
            fl_next_ok[i] = 1'b0;
        end
        link_pages(1, INIT_EFF);
        fl_head    = PW'(1);
        fl_head_ok = INIT_EFF > 1;
        pool_pages = CW'(INIT_EFF);
    endtask

    task automatic predict_reply(input logic op, input logic [PN_W-1:0] pg,
                                 output t_page_reply r);
        int            doubled;
        logic [PW-1:0] taken;
        r.page = '0;
        if (op == OP_FREE) begin
            // pages with no link entry are dropped but still reported as freed
            if (int'(pg) < MAX_PAGES) begin
                fl_next[int'(pg)]    = fl_head;
                fl_next_ok[int'(pg)] = fl_head_ok;
                fl_head              = PW'(pg);
                fl_head_ok           = 1'b1;
            end
            r.st = ST_FREED;
        end else begin
            r.st = ST_ALLOC;
            if (!fl_head_ok) begin
                doubled = 2 * int'(pool_pages);
                if (doubled > MAX_PAGES) begin
                    r.st      = ST_FULL;
                    full_seen = 1'b1;
                    return;
                end
                link_pages(int'(pool_pages), doubled);
                fl_head    = PW'(pool_pages);
                fl_head_ok = 1'b1;
                pool_pages = CW'(doubled);
                r.st       = ST_ALLOC_GROWN;
            end
            taken      = fl_head;
            r.page     = PN_W'(taken);
            lent_pages.push_back(taken);
            fl_head_ok = fl_next_ok[taken];
            fl_head    = fl_next[taken];
        end
    endtask

    function automatic bit on_free_list(input int pg);
        logic [PW-1:0] cur;
        bit            ok;
        int            n;
        cur = fl_head;
        ok  = fl_head_ok;
        for (n = 0; n < MAX_PAGES && ok; n++) begin
            if (int'(cur) == pg) return 1'b1;
            ok  = fl_next_ok[cur];
            cur = fl_next[cur];
        end
        return 1'b0;
    endfunction

    // a stray free must not hit a page that is lent out or already free,
    // otherwise the list closes into a loop and never drains again
    function automatic bit stray_ok(input logic [PN_W-1:0] pg);
        if (int'(pg) >= MAX_PAGES) return 1'b1;
        if (on_free_list(int'(pg))) return 1'b0;
        foreach (lent_pages[i]) if (int'(lent_pages[i]) == int'(pg)) return 1'b0;
        foreach (chunk_frees[i]) if (chunk_frees[i] == pg) return 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_req(input logic op, input logic [PN_W-1:0] pg, input bit drain);
        t_page_req r;
        r.op    = op;
        r.pg    = pg;
        r.drain = drain;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_lent_free(input bit drain);
        int            idx;
        logic [PW-1:0] p;
        idx = $urandom_range(lent_pages.size() - 1);
        p   = lent_pages[idx];
        lent_pages.delete(idx);
        // a doubling may have relinked a page that a stray free brought in
        if (on_free_list(int'(p))) begin
            queue_req(OP_ALLOC, PN_W'($urandom), drain);
        end else begin
            queue_req(OP_FREE, PN_W'(p), drain);
            chunk_frees.push_back(PN_W'(p));
        end
    endtask

    task automatic queue_random_chunk(input int n, input bit drain_first);
        logic [PN_W-1:0] pg;
        bit              stray_done;
        bit              d;
        int              k;
        int              tries;
        stray_done = 1'b0;
        chunk_frees.delete();
        for (k = 0; k < n; k++) begin
            d  = drain_first && k == 0;
            pg = PN_W'($urandom);
            if ($urandom_range(99) < (full_seen ? 50 : 92)) begin
                queue_req(OP_ALLOC, pg, d);
            end else if (lent_pages.size() != 0 && $urandom_range(3) != 0) begin
                queue_lent_free(d);
            end else begin
                for (tries = 0; tries < 8 && !stray_ok(pg); tries++) pg = PN_W'($urandom);
                if (!stray_done && stray_ok(pg)) begin
                    queue_req(OP_FREE, pg, d);
                    chunk_frees.push_back(pg);
                    stray_done = 1'b1;
                end else begin
                    queue_req(OP_ALLOC, pg, d);
                end
            end
        end
    endtask

    // returns once every queued transaction has been taken by the block
    task automatic send_all();
        while (pending_reqs.size() != 0 || (start && !acc_q)) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
    endtask

    always @(negedge i_clk) begin : drive_req
        t_page_req nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || acc_q) begin
            if (pending_reqs.size() != 0
                && !(pending_reqs[0].drain && awaited_replies.size() != 0)
                && $urandom_range(99) >= idle_pct) begin
                nxt = pending_reqs.pop_front();
                start         <= 1'b1;
                i_opcode      <= nxt.op;
                i_page_number <= nxt.pg;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch_reply
        t_page_reply want;
        acc_q <= i_rst_n && start && busy === 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (awaited_replies.size() == 0) begin
                    note_failure($sformatf("unexpected result page=%0d status=%0d",
                                           o_given_page, o_status));
                end else begin
                    want = awaited_replies.pop_front();
                    if (o_given_page !== want.page)
                        note_failure($sformatf("given_page: expected %0d, got %0d",
                                               want.page, o_given_page));
                    if (o_status !== want.st)
                        note_failure($sformatf("status: expected %0d, got %0d",
                                               want.st, o_status));
                end
            end else if (o_valid !== 1'b0) begin
                note_failure("o_valid unknown");
            end
            if (start && busy === 1'b0) begin
                predict_reply(i_opcode, i_page_number, want);
                awaited_replies.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int sent;
        int n;
        clear_free_list();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first pages off the initial chain
        repeat (3) queue_req(OP_ALLOC, PN_W'($urandom), 1'b0);
        send_all();
        // give one back, then push header and pages outside the pool
        chunk_frees.delete();
        queue_lent_free(1'b0);
        queue_req(OP_FREE, PN_W'(0), 1'b0);
        queue_req(OP_FREE, {PN_W{1'b1}}, 1'b0);
        queue_req(OP_FREE, PN_W'(10'h155), 1'b0);
        queue_req(OP_FREE, PN_W'(10'h2aa), 1'b0);
        queue_req(OP_FREE, PN_W'(10'h200), 1'b0);
        repeat (7) queue_req(OP_ALLOC, PN_W'($urandom), 1'b0);
        send_all();

        sent = 0;
        while (sent < N_RANDOM) begin
            idle_pct = idle_sched[sent * 4 / N_RANDOM];
            n = $urandom_range(16, 1);
            queue_random_chunk(n, sent == 0 || $urandom_range(9) == 0);
            send_all();
            sent += n;
        end

        // free a page that is already free: the list turns into a loop
        idle_pct = 0;
        if (fl_head_ok) begin
            queue_req(OP_FREE, PN_W'(fl_head), 1'b1);
        end else if (lent_pages.size() != 0) begin
            queue_req(OP_FREE, PN_W'(lent_pages[0]), 1'b1);
            queue_req(OP_FREE, PN_W'(lent_pages[0]), 1'b0);
        end
        repeat (4) queue_req(OP_ALLOC, PN_W'($urandom), 1'b0);
        send_all();

        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== page_free_list_allocator.f =====
sv/pfla_pkg.sv
sv/pfla_dp.sv
sv/pfla_ctrl.sv
sv/page_free_list_allocator.sv
test/page_free_list_allocator_tb.sv
